// ----- rtl/core/rtnb_pkg.sv -----
// Shared constants, types, microcode ROM and count helpers for the radix tree node builder.
`timescale 1ns / 1ps

package rtnb_pkg;

	// Code table geometry.
	localparam int CODE_DEPTH = 1024;
	localparam int CODE_BITS  = 64;

	// Derived widths.
	localparam int IDX_W   = $clog2(CODE_DEPTH);
	localparam int CNT_W   = $clog2(CODE_DEPTH + 1);
	localparam int LEN_W   = IDX_W + 1;
	localparam int POS_W   = IDX_W + 2;
	localparam int LZC_W   = $clog2(CODE_BITS + 1);
	localparam int IDXLZ_W = $clog2(IDX_W + 1);

	// Prefix lengths run from -1 (outside the table) up to 128 (a key against itself).
	localparam int DLT_W    = 9;
	localparam int TIE_BASE = 64;
	localparam int TIE_PAD  = 64 - IDX_W;

	// Fixed field widths of the stream ports.
	localparam int NIDX_W      = 10;
	localparam int MC_W        = 64;
	localparam int CFG_W       = 11;
	localparam int OUT_W       = 10;
	localparam int IN_TDATA_W  = ((NIDX_W + MC_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((3 * OUT_W + 2 + 7) / 8) * 8;
	localparam int MIN_COUNT   = 2;
	localparam int CFG_RESET   = 2;

	// Request kinds carried in tuser.
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_BUILD = 1'b1;

	// Control word fields.
	localparam int PC_W = 4;
	localparam int RD_W = 3;
	localparam int EV_W = 4;
	localparam int JC_W = 2;

	// Table read address sources.
	localparam logic [RD_W-1:0] RD_NONE = 3'd0;
	localparam logic [RD_W-1:0] RD_I    = 3'd1;
	localparam logic [RD_W-1:0] RD_IP1  = 3'd2;
	localparam logic [RD_W-1:0] RD_IM1  = 3'd3;
	localparam logic [RD_W-1:0] RD_EXP  = 3'd4;
	localparam logic [RD_W-1:0] RD_BIN  = 3'd5;
	localparam logic [RD_W-1:0] RD_J    = 3'd6;

	// Operations on the data read in the previous step.
	localparam logic [EV_W-1:0] EV_NONE     = 4'd0;
	localparam logic [EV_W-1:0] EV_CI       = 4'd1;
	localparam logic [EV_W-1:0] EV_DPLUS    = 4'd2;
	localparam logic [EV_W-1:0] EV_DMINUS   = 4'd3;
	localparam logic [EV_W-1:0] EV_EXP      = 4'd4;
	localparam logic [EV_W-1:0] EV_BIN_DMIN = 4'd5;
	localparam logic [EV_W-1:0] EV_TOP      = 4'd6;
	localparam logic [EV_W-1:0] EV_BIN_TOP  = 4'd7;
	localparam logic [EV_W-1:0] EV_EMIT     = 4'd8;

	// Jump conditions.
	localparam logic [JC_W-1:0] JC_NEXT = 2'd0;
	localparam logic [JC_W-1:0] JC_HIT  = 2'd1;
	localparam logic [JC_W-1:0] JC_STEP = 2'd2;
	localparam logic [JC_W-1:0] JC_END  = 2'd3;

	// Program labels.
	localparam logic [PC_W-1:0] PC_START   = 4'd0;
	localparam logic [PC_W-1:0] PC_EXP_RD  = 4'd4;
	localparam logic [PC_W-1:0] PC_BIN1_RD = 4'd6;
	localparam logic [PC_W-1:0] PC_BIN2_RD = 4'd10;

	typedef struct packed {
		logic [RD_W-1:0] rd_sel;
		logic [EV_W-1:0] ev_op;
		logic [JC_W-1:0] jc;
		logic [PC_W-1:0] target;
	} ucw_t;

	typedef struct packed {
		logic hit;
		logic step_gt1;
	} dp_stat_t;

	typedef struct packed {
		logic [OUT_W-1:0] left_child;
		logic             left_is_leaf;
		logic [OUT_W-1:0] right_child;
		logic             right_is_leaf;
		logic [OUT_W-1:0] range_end;
	} res_t;

	localparam ucw_t UCW_NOP = '{RD_NONE, EV_NONE, JC_NEXT, PC_START};

	// Node build program. Each probe is a read step followed by an evaluate step.
	function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
		ucw_t w;
		unique case (pc)
			4'd0:    w = '{RD_I,    EV_NONE,     JC_NEXT, PC_START};
			4'd1:    w = '{RD_IP1,  EV_CI,       JC_NEXT, PC_START};
			4'd2:    w = '{RD_IM1,  EV_DPLUS,    JC_NEXT, PC_START};
			4'd3:    w = '{RD_NONE, EV_DMINUS,   JC_NEXT, PC_START};
			4'd4:    w = '{RD_EXP,  EV_NONE,     JC_NEXT, PC_START};
			4'd5:    w = '{RD_NONE, EV_EXP,      JC_HIT,  PC_EXP_RD};
			4'd6:    w = '{RD_BIN,  EV_NONE,     JC_NEXT, PC_START};
			4'd7:    w = '{RD_NONE, EV_BIN_DMIN, JC_STEP, PC_BIN1_RD};
			4'd8:    w = '{RD_J,    EV_NONE,     JC_NEXT, PC_START};
			4'd9:    w = '{RD_NONE, EV_TOP,      JC_NEXT, PC_START};
			4'd10:   w = '{RD_BIN,  EV_NONE,     JC_NEXT, PC_START};
			4'd11:   w = '{RD_NONE, EV_BIN_TOP,  JC_STEP, PC_BIN2_RD};
			4'd12:   w = '{RD_NONE, EV_EMIT,     JC_END,  PC_START};
			default: w = UCW_NOP;
		endcase
		return w;
	endfunction

	// Leading-zero count over the code width.
	function automatic logic [LZC_W-1:0] clz_code(input logic [CODE_BITS-1:0] x);
		logic [LZC_W-1:0] n;
		n = LZC_W'(CODE_BITS);
		for (int k = 0; k < CODE_BITS; k++) begin
			if (x[k]) n = LZC_W'(CODE_BITS - 1 - k);
		end
		return n;
	endfunction

	// Leading-zero count over the index width.
	function automatic logic [IDXLZ_W-1:0] clz_idx(input logic [IDX_W-1:0] x);
		logic [IDXLZ_W-1:0] n;
		n = IDXLZ_W'(IDX_W);
		for (int k = 0; k < IDX_W; k++) begin
			if (x[k]) n = IDXLZ_W'(IDX_W - 1 - k);
		end
		return n;
	endfunction

endpackage

// ----- rtl/core/rtnb_seq.sv -----
// Microcode sequencer: step counter, control word fetch and conditional jumps.
`timescale 1ns / 1ps

module rtnb_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              out_free,
	input  rtnb_pkg::dp_stat_t stat,
	output logic              busy,
	output rtnb_pkg::ucw_t    ctl
);
	import rtnb_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic            busy_q;
	ucw_t            w;

	assign w    = ucode(pc_q);
	assign ctl  = busy_q ? w : UCW_NOP;
	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= PC_START;
		end else if (!busy_q) begin
			if (start) begin
				busy_q <= 1'b1;
				pc_q   <= PC_START;
			end
		end else begin
			unique case (w.jc)
				JC_NEXT: pc_q <= pc_q + PC_W'(1);
				JC_HIT:  pc_q <= stat.hit ? w.target : pc_q + PC_W'(1);
				JC_STEP: pc_q <= stat.step_gt1 ? w.target : pc_q + PC_W'(1);
				JC_END: begin
					// Hold on the final step until the result register can take the result.
					if (out_free) busy_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/rtnb_dp.sv -----
// Datapath: code table, probe address generation, prefix length and search registers.
`timescale 1ns / 1ps

module rtnb_dp (
	input  logic                         clk,
	input  logic                         start,
	input  logic [rtnb_pkg::IDX_W-1:0]   node_idx,
	input  logic                         wr_en,
	input  logic [rtnb_pkg::IDX_W-1:0]   wr_addr,
	input  logic [rtnb_pkg::MC_W-1:0]    wr_data,
	input  logic [rtnb_pkg::CNT_W-1:0]   n_m1,
	input  rtnb_pkg::ucw_t               ctl,
	output rtnb_pkg::dp_stat_t           stat,
	output rtnb_pkg::res_t               res
);
	import rtnb_pkg::*;

	logic [CODE_BITS-1:0] mem [CODE_DEPTH];

	// Search state.
	logic [IDX_W-1:0]        i_q;
	logic [CODE_BITS-1:0]    ci_q;
	logic signed [DLT_W-1:0] dplus_q;
	logic signed [DLT_W-1:0] dmin_q;
	logic signed [DLT_W-1:0] top_q;
	logic                    dneg_q;
	logic [LEN_W-1:0]        lmax_q;
	logic [LEN_W-1:0]        step_q;
	logic [LEN_W-1:0]        shift_q;
	logic [IDX_W-1:0]        j_q;

	// Read stage.
	logic [CODE_BITS-1:0] rd_s1;
	logic [IDX_W-1:0]     pb_s1;
	logic                 oob_s1;

	// Probe address.
	logic [LEN_W:0]          step_inc;
	logic [LEN_W-1:0]        step_nx;
	logic [LEN_W-1:0]        k;
	logic                    neg;
	logic signed [POS_W-1:0] p;
	logic                    oob;
	logic                    rd_en;

	// Prefix evaluation.
	logic [CODE_BITS-1:0]    cx;
	logic [IDX_W-1:0]        ix;
	logic signed [DLT_W-1:0] delta;
	logic signed [DLT_W-1:0] ref_len;
	logic                    hit;

	// Result.
	logic signed [POS_W-1:0] split_raw;
	logic signed [POS_W-1:0] split;
	logic signed [POS_W-1:0] sp1;
	logic [IDX_W-1:0]        lo;
	logic [IDX_W-1:0]        hi;

	assign step_inc = {1'b0, step_q} + (LEN_W + 1)'(1);
	assign step_nx  = step_inc[LEN_W:1];

	always_comb begin
		unique case (ctl.rd_sel)
			RD_I: begin
				k   = '0;
				neg = 1'b0;
			end
			RD_IP1: begin
				k   = LEN_W'(1);
				neg = 1'b0;
			end
			RD_IM1: begin
				k   = LEN_W'(1);
				neg = 1'b1;
			end
			RD_EXP: begin
				k   = lmax_q;
				neg = dneg_q;
			end
			RD_BIN: begin
				k   = shift_q + step_nx;
				neg = dneg_q;
			end
			RD_J: begin
				k   = shift_q;
				neg = dneg_q;
			end
			default: begin
				k   = '0;
				neg = 1'b0;
			end
		endcase
	end

	assign p     = neg ? $signed(POS_W'(i_q)) - $signed(POS_W'(k))
	                   : $signed(POS_W'(i_q)) + $signed(POS_W'(k));
	assign oob   = p[POS_W-1] || (p > $signed(POS_W'(n_m1)));
	assign rd_en = (ctl.rd_sel != RD_NONE);

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= CODE_BITS'(wr_data);
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_s1  <= mem[p[IDX_W-1:0]];
			pb_s1  <= p[IDX_W-1:0];
			oob_s1 <= oob;
		end
	end

	// Common prefix of the key at node i and the key just read.
	assign cx = rd_s1 ^ ci_q;
	assign ix = i_q ^ pb_s1;

	always_comb begin
		if (oob_s1) begin
			delta = '1;
		end else if (cx == '0) begin
			delta = DLT_W'(TIE_BASE + TIE_PAD) + DLT_W'(clz_idx(ix));
		end else begin
			delta = DLT_W'(clz_code(cx));
		end
	end

	assign ref_len = (ctl.ev_op == EV_BIN_TOP) ? top_q : dmin_q;
	assign hit     = delta > ref_len;

	assign stat.hit      = hit;
	assign stat.step_gt1 = step_q > LEN_W'(1);

	always_ff @(posedge clk) begin
		if (start) i_q <= node_idx;
		if (ctl.rd_sel == RD_BIN) step_q <= step_nx;
		unique case (ctl.ev_op)
			EV_CI:    ci_q    <= rd_s1;
			EV_DPLUS: dplus_q <= delta;
			EV_DMINUS: begin
				// A tie between the two neighbors counts as the upward direction.
				dneg_q <= !(dplus_q >= delta);
				dmin_q <= (dplus_q >= delta) ? delta : dplus_q;
				lmax_q <= LEN_W'(2);
			end
			EV_EXP: begin
				if (hit) begin
					lmax_q <= lmax_q << 1;
				end else begin
					step_q  <= lmax_q;
					shift_q <= '0;
				end
			end
			EV_BIN_DMIN, EV_BIN_TOP: begin
				if (hit) shift_q <= shift_q + step_q;
			end
			EV_TOP: begin
				// The first search leaves the range length in shift.
				top_q   <= delta;
				j_q     <= pb_s1;
				step_q  <= shift_q;
				shift_q <= '0;
			end
			default: begin
			end
		endcase
	end

	// Split position, clamped at zero for a downward range.
	assign split_raw = dneg_q
		? $signed(POS_W'(i_q)) - $signed(POS_W'(shift_q)) - $signed(POS_W'(1))
		: $signed(POS_W'(i_q)) + $signed(POS_W'(shift_q));
	assign split = split_raw[POS_W-1] ? '0 : split_raw;
	assign sp1   = split + $signed(POS_W'(1));
	assign lo    = (i_q < j_q) ? i_q : j_q;
	assign hi    = (i_q < j_q) ? j_q : i_q;

	assign res.left_child    = OUT_W'(split);
	assign res.left_is_leaf  = ($signed(POS_W'(lo)) == split);
	assign res.right_child   = OUT_W'(sp1);
	assign res.right_is_leaf = ($signed(POS_W'(hi)) == sp1);
	assign res.range_end     = OUT_W'(j_q);

endmodule

// ----- rtl/core/radix_tree_node_builder.sv -----
// Top level of the radix tree node builder: stream ports, count register and result register.
`timescale 1ns / 1ps

// The block holds a table of sorted Morton codes and builds one internal node of
// a binary radix tree per request. Requests arrive on the s_axis channel; tuser
// selects the kind. A write transfer (tuser 0) stores the code in tdata at the slot
// given by the node index and produces no result. A build transfer (tuser 1) names
// an internal node; the block finds the direction and far end of the node's key
// range and its split position, then sends one transfer on m_axis with both
// children, their leaf flags and the range end. A build that names no internal
// node (index at or above count-1) is dropped without a result.
// Writes and dropped builds do not make the block busy. A build runs an exponential
// search and two binary searches; each probe is one table read followed by one prefix
// evaluation through the single table read port. Only one build is in flight;
// s_axis_tready is low while it runs. The result register frees the sequencer once
// it is loaded, so a new request is taken while a result waits on m_axis. If the
// receiver stalls with a result still pending, the next build holds on its last step
// until the register empties. Reset clears the control state, empties the result
// register and sets the code count to 2; the code table is not cleared and must be
// written before it is read. cfg_wdata is the code count; the user must write it
// only while the block is idle, since the block itself does not enforce this.

module radix_tree_node_builder (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// node_index [9:0], morton_code [73:10], zero fill above
	input  logic [rtnb_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// req_type [0]
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// left_child [9:0], left_is_leaf [10], right_child [20:11],
	// right_is_leaf [21], range_end [31:22]
	output logic [rtnb_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                             cfg_we,
	input  logic [rtnb_pkg::CFG_W-1:0]       cfg_wdata
);
	import rtnb_pkg::*;

	logic [CFG_W-1:0]  cfg_q;
	logic [CNT_W-1:0]  n_act;
	logic [CNT_W-1:0]  n_m1;
	logic [NIDX_W-1:0] node_index;
	logic [MC_W-1:0]   morton_code;
	logic              accept;
	logic              start;
	logic              wr_en;
	logic              busy;
	logic              out_free;
	logic              emit;
	ucw_t              ctl;
	dp_stat_t          stat;
	res_t              res;
	res_t              res_q;
	logic              m_valid_q;

	assign node_index  = s_axis_tdata[NIDX_W-1:0];
	assign morton_code = s_axis_tdata[NIDX_W+MC_W-1:NIDX_W];

	// The count in use is the register saturated to the table depth range.
	always_comb begin
		priority if (32'(cfg_q) < MIN_COUNT) begin
			n_act = CNT_W'(MIN_COUNT);
		end else if (32'(cfg_q) > CODE_DEPTH) begin
			n_act = CNT_W'(CODE_DEPTH);
		end else begin
			n_act = CNT_W'(cfg_q);
		end
	end
	assign n_m1 = n_act - CNT_W'(1);

	assign s_axis_tready = !busy;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign start         = accept && (s_axis_tuser == REQ_BUILD)
	                       && (32'(node_index) < 32'(n_m1));
	assign wr_en         = accept && (s_axis_tuser == REQ_WRITE)
	                       && (32'(node_index) < CODE_DEPTH);

	assign out_free = !m_valid_q || m_axis_tready;
	assign emit     = (ctl.ev_op == EV_EMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_W'(CFG_RESET);
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	rtnb_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.out_free (out_free),
		.stat     (stat),
		.busy     (busy),
		.ctl      (ctl)
	);

	rtnb_dp u_dp (
		.clk      (clk),
		.start    (start),
		.node_idx (IDX_W'(node_index)),
		.wr_en    (wr_en),
		.wr_addr  (IDX_W'(node_index)),
		.wr_data  (morton_code),
		.n_m1     (n_m1),
		.ctl      (ctl),
		.stat     (stat),
		.res      (res)
	);

	// Result register: one transfer waits here while the sequencer takes new work.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) res_q <= res;
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'({res_q.range_end, res_q.right_is_leaf,
	                                     res_q.right_child, res_q.left_is_leaf,
	                                     res_q.left_child});

endmodule
